// ----- design/sacc_pkg.sv -----
// Shared types and constants of the set-associative cache tag controller.
`default_nettype none
package sacc_pkg;
   localparam int ADDR_W     = 32;
   localparam int OFFSET_W   = 5;
   localparam int SET_W      = 8;
   localparam int NUM_SETS   = 1 << SET_W;
   localparam int TAG_W      = ADDR_W - OFFSET_W - SET_W;
   localparam int NUM_WAYS   = 8;
   localparam int WAY_W      = 3;
   localparam int PAIRS      = NUM_WAYS / 2;
   localparam int QUADS      = PAIRS / 2;
   localparam int STAMP_W    = 32;
   localparam int CFG_WAYS_W = 4;
   localparam int CSR_DATA_W = 4;
   localparam int RSP_W      = 8;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic POLICY_LRU  = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_WAYS   = 1'b1;

   typedef struct packed {
      logic [NUM_WAYS-1:0]              valid;
      logic [NUM_WAYS-1:0]              dirty;
      logic [NUM_WAYS-1:0][TAG_W-1:0]   tag;
      logic [NUM_WAYS-1:0][STAMP_W-1:0] stamp;
   } set_row_type;

   typedef struct packed {
      logic              en;
      logic [SET_W-1:0]  addr;
   } ram_rd_type;

   typedef struct packed {
      logic              en;
      logic [SET_W-1:0]  addr;
      set_row_type       data;
   } ram_wr_type;
endpackage
`default_nettype wire

// ----- design/sacc_tag_ram.sv -----
// Set-row memory with per-set valid flags and write-to-read forwarding.
`default_nettype none
module sacc_tag_ram (
   input  wire                    clock,
   input  wire                    reset,
   input  sacc_pkg::ram_rd_type   rd,
   input  sacc_pkg::ram_wr_type   wr,
   output sacc_pkg::set_row_type  rd_row
);
   sacc_pkg::set_row_type mem [sacc_pkg::NUM_SETS];
   logic [sacc_pkg::NUM_SETS-1:0] row_live_ff;
   sacc_pkg::set_row_type         rd_data_ff;
   logic                          rd_live_ff;
   logic                          fwd;

   assign fwd = wr.en && (wr.addr == rd.addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= fwd ? wr.data : mem[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_live_ff <= '0;
         rd_live_ff  <= 1'b0;
      end else begin
         if (wr.en) begin
            row_live_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            rd_live_ff <= fwd || row_live_ff[rd.addr];
         end
      end
   end

   always_comb begin
      rd_row = rd_data_ff;
      if (!rd_live_ff) begin
         rd_row.valid = '0;
         rd_row.dirty = '0;
      end
   end
endmodule
`default_nettype wire

// ----- design/set_assoc_cache_tag_controller.sv -----
// Set-associative write-back cache tag controller, LRU or FIFO replacement.
// Each request passes through the pick and commit states: the set row is read from
// the row memory at acceptance, the next cycle compares tags and runs the first
// level of the oldest-stamp search, and the commit state finishes the search,
// writes the row back and loads the result register; the next request is taken
// in that commit cycle, with the row memory forwarding a same-set write. A
// stalled result holds the controller in its commit cycle. Per-set valid flags
// clear at reset, so no clearing pass is needed. Configuration is always ready.
`default_nettype none
module set_assoc_cache_tag_controller (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [sacc_pkg::ADDR_W-1:0]        req_tdata,  // address
   input  wire                                req_tuser,  // op
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [sacc_pkg::RSP_W-1:0]         rsp_tdata,  // hit, writeback, way, zero pad
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire                                csr_addr,
   input  wire  [sacc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_PICK   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic                                   policy_ff;
   logic [sacc_pkg::CFG_WAYS_W-1:0]        ways_ff;
   logic                                   op_ff;
   logic [sacc_pkg::TAG_W-1:0]             tag_ff;
   logic [sacc_pkg::SET_W-1:0]             set_ff;
   logic [sacc_pkg::STAMP_W-1:0]           count_ff;
   logic [sacc_pkg::NUM_WAYS-1:0]          hit_vec_ff, hit_vec_in;
   logic [sacc_pkg::NUM_WAYS-1:0]          inval_vec_ff, inval_vec_in;
   logic [sacc_pkg::PAIRS-1:0][sacc_pkg::STAMP_W-1:0] pair_stamp_ff, pair_stamp_in;
   logic [sacc_pkg::PAIRS-1:0][sacc_pkg::WAY_W-1:0]   pair_idx_ff, pair_idx_in;
   logic [sacc_pkg::PAIRS-1:0]             pair_act_ff, pair_act_in;
   logic                                   rsp_valid_ff;
   logic [sacc_pkg::RSP_W-1:0]             rsp_data_ff, rsp_data_in;

   sacc_pkg::ram_rd_type                   ram_rd;
   sacc_pkg::ram_wr_type                   ram_wr;
   sacc_pkg::set_row_type                  row;
   sacc_pkg::set_row_type                  row_new;

   logic [sacc_pkg::NUM_WAYS-1:0]          active;
   logic [sacc_pkg::CFG_WAYS_W-1:0]        ways_eff;
   logic                                   req_accept;
   logic                                   out_free;
   logic                                   commit;
   logic                                   hit;
   logic                                   any_inval;
   logic                                   wb;
   logic [sacc_pkg::WAY_W-1:0]             hit_way, inval_way, old_way, victim;
   logic [sacc_pkg::QUADS-1:0][sacc_pkg::STAMP_W-1:0] quad_stamp;
   logic [sacc_pkg::QUADS-1:0][sacc_pkg::WAY_W-1:0]   quad_idx;
   logic [sacc_pkg::QUADS-1:0]             quad_act;
   logic [sacc_pkg::STAMP_W-1:0]           stamp_new;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_COMMIT) && out_free;
   assign req_tready = (state_ff == ST_IDLE) || commit;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;
   assign stamp_new  = count_ff + sacc_pkg::STAMP_W'(1);

   // clamp ways in use to one through the full associativity
   always_comb begin
      if (ways_ff == '0) begin
         ways_eff = sacc_pkg::CFG_WAYS_W'(1);
      end else if (ways_ff > sacc_pkg::CFG_WAYS_W'(sacc_pkg::NUM_WAYS)) begin
         ways_eff = sacc_pkg::CFG_WAYS_W'(sacc_pkg::NUM_WAYS);
      end else begin
         ways_eff = ways_ff;
      end
      for (int w = 0; w < sacc_pkg::NUM_WAYS; w++) begin
         active[w] = sacc_pkg::CFG_WAYS_W'(w) < ways_eff;
      end
   end

   sacc_tag_ram u_ram (
      .clock  (clock),
      .reset  (reset),
      .rd     (ram_rd),
      .wr     (ram_wr),
      .rd_row (row)
   );

   always_comb begin
      ram_rd.en   = req_accept;
      ram_rd.addr = req_tdata[sacc_pkg::OFFSET_W +: sacc_pkg::SET_W];
   end

   // compare tags and run the first level of the oldest-stamp search
   always_comb begin
      for (int w = 0; w < sacc_pkg::NUM_WAYS; w++) begin
         hit_vec_in[w]   = active[w] && row.valid[w] && (row.tag[w] == tag_ff);
         inval_vec_in[w] = active[w] && !row.valid[w];
      end
      for (int p = 0; p < sacc_pkg::PAIRS; p++) begin
         if (active[2*p+1] && (row.stamp[2*p+1] < row.stamp[2*p])) begin
            pair_stamp_in[p] = row.stamp[2*p+1];
            pair_idx_in[p]   = sacc_pkg::WAY_W'(2*p+1);
         end else begin
            pair_stamp_in[p] = row.stamp[2*p];
            pair_idx_in[p]   = sacc_pkg::WAY_W'(2*p);
         end
         pair_act_in[p] = active[2*p];
      end
   end

   // finish the search, pick the way and build the row to write back
   always_comb begin
      hit_way   = '0;
      inval_way = '0;
      for (int w = sacc_pkg::NUM_WAYS - 1; w >= 0; w--) begin
         if (hit_vec_ff[w]) begin
            hit_way = sacc_pkg::WAY_W'(w);
         end
         if (inval_vec_ff[w]) begin
            inval_way = sacc_pkg::WAY_W'(w);
         end
      end
      hit       = |hit_vec_ff;
      any_inval = |inval_vec_ff;

      for (int q = 0; q < sacc_pkg::QUADS; q++) begin
         if (pair_act_ff[2*q+1] && (pair_stamp_ff[2*q+1] < pair_stamp_ff[2*q])) begin
            quad_stamp[q] = pair_stamp_ff[2*q+1];
            quad_idx[q]   = pair_idx_ff[2*q+1];
         end else begin
            quad_stamp[q] = pair_stamp_ff[2*q];
            quad_idx[q]   = pair_idx_ff[2*q];
         end
         quad_act[q] = pair_act_ff[2*q];
      end
      if (quad_act[1] && (quad_stamp[1] < quad_stamp[0])) begin
         old_way = quad_idx[1];
      end else begin
         old_way = quad_idx[0];
      end

      if (hit) begin
         victim = hit_way;
      end else if (any_inval) begin
         victim = inval_way;
      end else begin
         victim = old_way;
      end

      wb      = !hit && row.valid[victim] && row.dirty[victim];
      row_new = row;
      if (hit) begin
         if (policy_ff == sacc_pkg::POLICY_LRU) begin
            row_new.stamp[victim] = stamp_new;
         end
         if (op_ff == sacc_pkg::OP_WRITE) begin
            row_new.dirty[victim] = 1'b1;
         end
      end else begin
         row_new.tag[victim]   = tag_ff;
         row_new.stamp[victim] = stamp_new;
         row_new.dirty[victim] = (op_ff == sacc_pkg::OP_WRITE);
         row_new.valid[victim] = 1'b1;
      end

      ram_wr.en   = commit;
      ram_wr.addr = set_ff;
      ram_wr.data = row_new;

      rsp_data_in = {{(sacc_pkg::RSP_W - sacc_pkg::WAY_W - 2){1'b0}}, victim, wb, hit};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit) begin
               state_in = req_accept ? ST_PICK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= sacc_pkg::POLICY_LRU;
         ways_ff      <= sacc_pkg::CFG_WAYS_W'(sacc_pkg::NUM_WAYS);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_addr)
               sacc_pkg::CSR_POLICY: policy_ff <= csr_wdata[0];
               sacc_pkg::CSR_WAYS:   ways_ff   <= csr_wdata[sacc_pkg::CFG_WAYS_W-1:0];
               default: begin
               end
            endcase
         end
         if (commit) begin
            count_ff     <= stamp_new;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_tuser;
         set_ff <= req_tdata[sacc_pkg::OFFSET_W +: sacc_pkg::SET_W];
         tag_ff <= req_tdata[sacc_pkg::ADDR_W-1 -: sacc_pkg::TAG_W];
      end
      if (state_ff == ST_PICK) begin
         hit_vec_ff    <= hit_vec_in;
         inval_vec_ff  <= inval_vec_in;
         pair_stamp_ff <= pair_stamp_in;
         pair_idx_ff   <= pair_idx_in;
         pair_act_ff   <= pair_act_in;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end
endmodule
`default_nettype wire

// ----- design/sacc_checker.sv -----
// Port-level checks of the cache tag controller and their bind.
`default_nettype none
module sacc_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_tvalid,
   input wire                               req_tready,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [sacc_pkg::RSP_W-1:0]         rsp_tdata,
   input wire                               csr_valid,
   input wire                               csr_ready
);
   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("controller not idle after reset");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready && !req_fire)
      else $error("request taken while previous one is in lookup");

   a_hit_no_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("writeback reported on a hit");

   a_cfg_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");
endmodule

bind set_assoc_cache_tag_controller sacc_checker u_sacc_checker (.*);
`default_nettype wire
